// File: rtl/wetd_pkg.sv
// ----------------------------------------------------------------------------
// wetd_pkg
// Shared types and constants for the weighted edge table with node degrees.
// ----------------------------------------------------------------------------
package wetd_pkg;

    localparam int NODE_W       = 6;
    localparam int IN_WEIGHT_W  = 16;
    localparam int OUT_WEIGHT_W = 16;
    localparam int COUNT_W      = 7;
    localparam int SUM_W        = 23;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QEDGE  = 2'd2,
        OP_QDEG   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_WR_A,
        ST_WR_B,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic load_item;
        logic rd_a;
        logic rd_b;
        logic wr_a;
        logic wr_b;
        logic load_result;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic is_query;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/weighted_edge_table_with_degrees.sv
// ----------------------------------------------------------------------------
// weighted_edge_table_with_degrees
// Undirected weighted edge table with per-node neighbor count and weighted
// degree.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall) carries one beat per item: an
// operation, two nodes and a weight. The output channel (out_valid /
// out_stall) returns exactly one result beat per item, in order.
// After rst_n is released the block sweeps the edge and degree memories to
// zero, one entry per cycle, through all 2^(2*ceil(log2 NODE_COUNT)) edge
// entries (4096 at the defaults); in_stall stays high during the sweep.
// Add and remove go from acceptance to out_valid through two reads through
// the single read port of the degree memory (one per endpoint), two writes
// and the load of the output register. Queries skip the writes. The next
// item is accepted the cycle after the previous one has moved into the output
// register, so no new item is taken before the last one has reached it.
// While the receiver stalls, the finished beat holds in the output register;
// the block still accepts and works on the next item, and waits only when that
// item's result is ready and the register is still full.
// ----------------------------------------------------------------------------
module weighted_edge_table_with_degrees
    import wetd_pkg::*;
#(
    parameter int NODE_COUNT  = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              operation,
    input  logic [NODE_W-1:0]       node_a,
    input  logic [NODE_W-1:0]       node_b,
    input  logic [IN_WEIGHT_W-1:0]  edge_weight_in,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    edge_present,
    output logic [OUT_WEIGHT_W-1:0] edge_weight_out,
    output logic [COUNT_W-1:0]      neighbor_total,
    output logic [SUM_W-1:0]        weight_sum
);

    cmd_t cmd;
    sts_t sts;

    wetd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    wetd_dp #(
        .NODE_COUNT  (NODE_COUNT),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .operation       (operation),
        .node_a          (node_a),
        .node_b          (node_b),
        .edge_weight_in  (edge_weight_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .edge_present    (edge_present),
        .edge_weight_out (edge_weight_out),
        .neighbor_total  (neighbor_total),
        .weight_sum      (weight_sum)
    );

endmodule

// File: rtl/wetd_ram.sv
// ----------------------------------------------------------------------------
// wetd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wetd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// File: rtl/wetd_dp.sv
// ----------------------------------------------------------------------------
// wetd_dp
// Datapath: item registers, edge and degree memories, degree update
// arithmetic, clearing sweep and the result register.
// ----------------------------------------------------------------------------
module wetd_dp
    import wetd_pkg::*;
#(
    parameter int NODE_COUNT  = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output sts_t                    sts,
    input  logic [1:0]              operation,
    input  logic [NODE_W-1:0]       node_a,
    input  logic [NODE_W-1:0]       node_b,
    input  logic [IN_WEIGHT_W-1:0]  edge_weight_in,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    edge_present,
    output logic [OUT_WEIGHT_W-1:0] edge_weight_out,
    output logic [COUNT_W-1:0]      neighbor_total,
    output logic [SUM_W-1:0]        weight_sum
);

    localparam int NB         = (NODE_COUNT > 2) ? $clog2(NODE_COUNT) : 1;
    // One bit wider than any node number, so that NODE_COUNT itself fits.
    localparam int IW         = ((NB > NODE_W) ? NB : NODE_W) + 1;
    localparam int WB         = (WEIGHT_BITS < IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;
    localparam int EAW        = 2 * NB;
    localparam int EDGE_DEPTH = 1 << EAW;
    localparam int DEG_DEPTH  = 1 << NB;
    localparam int DEG_W      = COUNT_W + SUM_W;

    logic [IW-1:0]      a_ext;
    logic [IW-1:0]      b_ext;

    op_t                op_reg;
    logic [NB-1:0]      a_reg;
    logic [NB-1:0]      b_reg;
    logic               a_ok_reg;
    logic               b_ok_reg;
    logic [WB-1:0]      w_reg;
    logic               old_v_reg;
    logic [WB-1:0]      old_w_reg;
    logic [COUNT_W-1:0] cnt_a_reg;
    logic [SUM_W-1:0]   sum_a_reg;
    logic [COUNT_W-1:0] cnt_b_reg;
    logic [SUM_W-1:0]   sum_b_reg;
    logic [EAW-1:0]     clr_cnt_reg;
    logic [EAW-1:0]     clr_cnt_next;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    edge_present_reg;
    logic [OUT_WEIGHT_W-1:0] edge_weight_out_reg;
    logic [COUNT_W-1:0]      neighbor_total_reg;
    logic [SUM_W-1:0]        weight_sum_reg;

    logic               both_ok;
    logic               self_loop;
    logic [NB-1:0]      lo_node;
    logic [NB-1:0]      hi_node;
    logic [EAW-1:0]     edge_addr;
    logic               edge_we;
    logic [EAW-1:0]     edge_waddr;
    logic [WB:0]        edge_wdata;
    logic [WB:0]        edge_rdata;
    logic               deg_we;
    logic               deg_re;
    logic [NB-1:0]      deg_waddr;
    logic [NB-1:0]      deg_raddr;
    logic [DEG_W-1:0]   deg_wdata;
    logic [DEG_W-1:0]   deg_rdata;

    logic [SUM_W-1:0]   add_w;
    logic [SUM_W-1:0]   sub_w;
    logic [SUM_W-1:0]   diff_w;
    logic [SUM_W-1:0]   delta_w;
    logic [COUNT_W-1:0] delta_cnt;
    logic [DEG_W-1:0]   new_a;
    logic [DEG_W-1:0]   new_b;

    assign a_ext = IW'(node_a);
    assign b_ext = IW'(node_b);

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= op_t'(operation);
            a_reg    <= a_ext[NB-1:0];
            b_reg    <= b_ext[NB-1:0];
            a_ok_reg <= (a_ext < IW'(NODE_COUNT));
            b_ok_reg <= (b_ext < IW'(NODE_COUNT));
            w_reg    <= edge_weight_in[WB-1:0];
        end
        if (cmd.rd_b)
        begin
            old_v_reg <= edge_rdata[WB];
            old_w_reg <= edge_rdata[WB-1:0];
            cnt_a_reg <= deg_rdata[DEG_W-1:SUM_W];
            sum_a_reg <= deg_rdata[SUM_W-1:0];
        end
        if (cmd.wr_a)
        begin
            cnt_b_reg <= deg_rdata[DEG_W-1:SUM_W];
            sum_b_reg <= deg_rdata[SUM_W-1:0];
        end
    end

    assign both_ok   = a_ok_reg && b_ok_reg;
    assign self_loop = (a_reg == b_reg);
    assign lo_node   = (a_reg < b_reg) ? a_reg : b_reg;
    assign hi_node   = (a_reg < b_reg) ? b_reg : a_reg;

    // The table is symmetric, so only the entry with the lower node first is kept.
    assign edge_addr = {lo_node, hi_node};

    // Degree change: the old weight leaves and the new one enters, twice for a self-loop.
    assign add_w     = (op_reg == OP_ADD) ? SUM_W'(w_reg) : '0;
    assign sub_w     = old_v_reg ? SUM_W'(old_w_reg) : '0;
    assign diff_w    = add_w - sub_w;
    assign delta_w   = self_loop ? {diff_w[SUM_W-2:0], 1'b0} : diff_w;
    assign delta_cnt = COUNT_W'(op_reg == OP_ADD) - COUNT_W'(old_v_reg);
    assign new_a     = {cnt_a_reg + delta_cnt, sum_a_reg + delta_w};
    assign new_b     = {cnt_b_reg + delta_cnt, sum_b_reg + delta_w};

    // Clearing sweep after reset.
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clear)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign edge_we    = cmd.clear || (cmd.wr_a && both_ok);
    assign edge_waddr = cmd.clear ? clr_cnt_reg : edge_addr;
    assign edge_wdata = (!cmd.clear && op_reg == OP_ADD) ? {1'b1, w_reg} : '0;

    wetd_ram #(
        .WIDTH (WB + 1),
        .DEPTH (EDGE_DEPTH)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .re    (cmd.rd_a),
        .raddr (edge_addr),
        .rdata (edge_rdata)
    );

    assign deg_re    = cmd.rd_a || cmd.rd_b;
    assign deg_raddr = cmd.rd_b ? b_reg : a_reg;
    assign deg_we    = cmd.clear || (cmd.wr_a && both_ok)
                       || (cmd.wr_b && both_ok && !self_loop);
    assign deg_waddr = cmd.clear ? clr_cnt_reg[NB-1:0] : (cmd.wr_b ? b_reg : a_reg);
    assign deg_wdata = cmd.clear ? '0 : (cmd.wr_b ? new_b : new_a);

    wetd_ram #(
        .WIDTH (DEG_W),
        .DEPTH (DEG_DEPTH)
    ) u_deg_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .re    (deg_re),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    // Result register; it frees up in the same cycle that its beat is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            edge_present_reg    <= (op_reg == OP_QEDGE) && both_ok && old_v_reg;
            edge_weight_out_reg <= ((op_reg == OP_QEDGE) && both_ok && old_v_reg)
                                   ? OUT_WEIGHT_W'(old_w_reg) : '0;
            neighbor_total_reg  <= ((op_reg == OP_QDEG) && a_ok_reg) ? cnt_a_reg : '0;
            weight_sum_reg      <= ((op_reg == OP_QDEG) && a_ok_reg) ? sum_a_reg : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign edge_present    = edge_present_reg;
    assign edge_weight_out = edge_weight_out_reg;
    assign neighbor_total  = neighbor_total_reg;
    assign weight_sum      = weight_sum_reg;

    assign sts.clr_last = &clr_cnt_reg;
    assign sts.is_query = (op_reg == OP_QEDGE) || (op_reg == OP_QDEG);
    assign sts.out_free = !out_valid_reg || !out_stall;

`ifndef NO_ASSERTIONS
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten while its beat was pending");

    a_clear_no_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !(cmd.wr_a || cmd.wr_b || cmd.load_item))
        else $error("table update during clearing sweep");

    a_sweep_advances: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (clr_cnt_reg == $past(clr_cnt_reg) + 1'b1))
        else $error("clearing sweep skipped an entry");
`endif

endmodule

// File: rtl/wetd_ctrl.sv
// ----------------------------------------------------------------------------
// wetd_ctrl
// Controller: sequences the clearing sweep, memory reads, degree and edge
// writes, and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module wetd_ctrl
    import wetd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RD_A;
                end
            end
            ST_RD_A:
            begin
                state_next = ST_RD_B;
            end
            ST_RD_B:
            begin
                state_next = sts.is_query ? ST_DONE : ST_WR_A;
            end
            ST_WR_A:
            begin
                state_next = ST_WR_B;
            end
            ST_WR_B:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.load_item = in_valid;
            end
            ST_RD_A:
            begin
                cmd.rd_a = 1'b1;
            end
            ST_RD_B:
            begin
                cmd.rd_b = 1'b1;
            end
            ST_WR_A:
            begin
                cmd.wr_a = 1'b1;
            end
            ST_WR_B:
            begin
                cmd.wr_b = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_result = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_sweep_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && !sts.clr_last) |=> (state_reg == ST_CLEAR))
        else $error("clearing sweep ended early");

    a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_B && sts.is_query) |=> (state_reg == ST_DONE))
        else $error("query entered a write phase");

    a_done_releases: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && sts.out_free) |=> (state_reg == ST_IDLE && !in_stall))
        else $error("controller did not return to idle after handing off result");

    a_update_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR_A) |-> ($past(state_reg) == ST_RD_B && !$past(sts.is_query)))
        else $error("degree write without preceding read");
`endif

endmodule
